>>> src/pfr_pkg.sv
// Package for the pixel format to RGB888 converter.
// Holds the pixel format codes, the RGB result type and the channel decode functions.
// No dependencies.
package pfr_pkg;

    typedef enum logic [2:0] {
        FMT_RGBA8   = 3'd0,
        FMT_BGRA8   = 3'd1,
        FMT_R8      = 3'd2,
        FMT_RGBA_HF = 3'd3,
        FMT_R_FLOAT = 3'd4,
        FMT_R_HALF  = 3'd5
    } t_pixel_format;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    localparam logic [4:0] HALF_EXP_ONE   = 5'd15;
    localparam logic [4:0] HALF_EXP_SHIFT = 5'd25;
    localparam logic [7:0] FLT_EXP_ONE    = 8'd127;
    localparam logic [7:0] FLT_EXP_MIN    = 8'd118;
    localparam logic [7:0] FLT_EXP_SHIFT  = 8'd150;

    // clamp to [0,1], times 255, truncate
    function automatic logic [7:0] half_to_byte(input logic [15:0] h);
        logic [4:0]  e;
        logic [10:0] sig;
        logic [18:0] prod;
        logic [4:0]  sh;
        logic [18:0] q;
        e    = h[14:10];
        sig  = {1'b1, h[9:0]};
        prod = {sig, 8'b0} - {8'b0, sig};
        sh   = HALF_EXP_SHIFT - e;
        q    = prod >> sh;
        if (e == 5'd0 || h[15]) begin
            half_to_byte = 8'd0;
        end else if (e >= HALF_EXP_ONE) begin
            half_to_byte = 8'hFF;
        end else begin
            half_to_byte = q[7:0];
        end
    endfunction

    // product rounded to 24 significant bits (ties to even), then truncated
    function automatic logic [7:0] float_to_byte(input logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] frac;
        logic [23:0] mant;
        logic [31:0] prod;
        logic [23:0] q;
        logic        rnd;
        logic [24:0] qr;
        logic [32:0] prodr;
        logic [7:0]  sc;
        logic [32:0] res;
        e    = f[30:23];
        frac = f[22:0];
        mant = {1'b1, frac};
        prod = {mant, 8'b0} - {8'b0, mant};
        if (prod[31]) begin
            q   = prod[31:8];
            rnd = prod[7] && ((prod[6:0] != 7'd0) || q[0]);
        end else begin
            q   = prod[30:7];
            rnd = prod[6] && ((prod[5:0] != 6'd0) || q[0]);
        end
        qr = {1'b0, q} + {24'd0, rnd};
        if (prod[31]) begin
            prodr = {qr, 8'b0};
        end else begin
            prodr = {1'b0, qr, 7'b0};
        end
        sc  = FLT_EXP_SHIFT - e;
        res = prodr >> sc;
        if (e == 8'hFF) begin
            float_to_byte = ((frac != 23'd0) || f[31]) ? 8'd0 : 8'hFF;
        end else if (f[31] || e < FLT_EXP_MIN) begin
            float_to_byte = 8'd0;
        end else if (e >= FLT_EXP_ONE) begin
            float_to_byte = 8'hFF;
        end else if (res > 33'd255) begin
            float_to_byte = 8'hFF;
        end else begin
            float_to_byte = res[7:0];
        end
    endfunction

endpackage

>>> src/pfr_decode.sv
// Pixel word decoder: picks and converts the three channels for the configured format.
// Depends on pfr_pkg.
module pfr_decode (
    input  pfr_pkg::t_pixel_format i_fmt,
    input  logic [63:0]            i_word,
    output pfr_pkg::t_rgb          o_rgb
);
    import pfr_pkg::*;

    logic [7:0] w_flt;
    logic [7:0] w_h0;
    logic [7:0] w_h1;
    logic [7:0] w_h2;

    assign w_flt = float_to_byte(i_word[31:0]);
    assign w_h0  = half_to_byte(i_word[15:0]);
    assign w_h1  = half_to_byte(i_word[31:16]);
    assign w_h2  = half_to_byte(i_word[47:32]);

    always_comb begin
        case (i_fmt)
            FMT_BGRA8: begin
                o_rgb = '{red: i_word[23:16], green: i_word[15:8], blue: i_word[7:0]};
            end
            FMT_R8: begin
                o_rgb = '{red: i_word[7:0], green: i_word[7:0], blue: i_word[7:0]};
            end
            FMT_RGBA_HF: begin
                o_rgb = '{red: w_h0, green: w_h1, blue: w_h2};
            end
            FMT_R_FLOAT: begin
                o_rgb = '{red: w_flt, green: w_flt, blue: w_flt};
            end
            FMT_R_HALF: begin
                o_rgb = '{red: w_h0, green: w_h0, blue: w_h0};
            end
            default: begin
                o_rgb = '{red: i_word[7:0], green: i_word[15:8], blue: i_word[23:16]};
            end
        endcase
    end

endmodule

>>> src/pixel_format_to_rgb8_unit.sv
// Pixel format to RGB888 converter, top level.
// Depends on pfr_pkg and pfr_decode.
//
// Input channel: i_valid / o_stall carry one 64-bit raw pixel word per
// transfer (byte 0 in bits 7:0). Output channel: o_valid / i_stall carry
// 8-bit red, green, blue. A word moves when valid is high and stall is low.
// i_cfg_we / i_cfg_data write the pixel format (0 rgba8, 1 bgra8, 2 r8,
// 3 rgba half, 4 r float, 5 r half, 6-7 as rgba8); change it only while idle.
// The data path is input register, decode, result register.
// Throughput is one word per cycle while the receiver does not stall; the decode is single pass.
// When the receiver stalls, the result register holds and the input
// register fills; o_stall rises only once both are full.
// Reset (synchronous, active low) empties both stages and sets format 0.
module pixel_format_to_rgb8_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_valid,
    input  logic [63:0] i_pixel_word,
    output logic        o_stall,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    input  logic        i_stall
);
    import pfr_pkg::*;

    t_pixel_format r_fmt;
    logic          r_s1_valid;
    logic          n_s1_valid;
    logic [63:0]   r_word;
    logic          r_out_valid;
    logic          n_out_valid;
    t_rgb          r_rgb;
    t_rgb          w_rgb;
    logic          w_in_take;
    logic          w_s1_adv;

    assign w_s1_adv  = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_s1_valid && r_out_valid && i_stall;
    assign w_in_take = i_valid && !o_stall;

    always_comb begin
        if (w_in_take) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
        if (w_s1_adv) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    pfr_decode u_decode (
        .i_fmt  (r_fmt),
        .i_word (r_word),
        .o_rgb  (w_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_RGBA8;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= t_pixel_format'(i_cfg_data);
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
        if (w_in_take) begin
            r_word <= i_pixel_word;
        end
        if (w_s1_adv) begin
            r_rgb <= w_rgb;
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_rgb.red;
    assign o_green = r_rgb.green;
    assign o_blue  = r_rgb.blue;

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("stall raised with a free stage");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted word not held in input stage");

    a_adv_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> o_valid)
        else $error("advanced word not presented");

    a_mono_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_fmt == FMT_R8 || r_fmt == FMT_R_FLOAT || r_fmt == FMT_R_HALF))
        |-> (o_red == o_green && o_green == o_blue))
        else $error("single channel format gave unequal channels");

endmodule
